// ----- rtl/core/brme_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package brme_pkg;

    localparam int WORD_BITS     = 64;
    localparam int SRC_WORDS_DEF = 16;
    localparam int DST_WORDS_DEF = 16;

    localparam int CMD_W  = 3;
    localparam int IDX_W  = 4;
    localparam int POS_W  = 10;
    localparam int LEN_W  = 11;
    localparam int WIDX_W = 5;   // word number of a bit position below 2048
    localparam int OFF_W  = 6;   // bit within a word
    localparam int CNT_W  = 7;   // bits in one step, 1..64

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD_SRC = 3'd0,
        CMD_LOAD_DST = 3'd1,
        CMD_READ_DST = 3'd2,
        CMD_MOVE     = 3'd3,
        CMD_SET      = 3'd4
    } cmd_t;

    typedef struct packed {
        logic              src_load;
        logic              dst_load;
        logic              dst_read;
        logic [IDX_W-1:0]  load_idx;
        logic              step;
        logic              fill;
        logic [WIDX_W-1:0] dw;
        logic [WIDX_W-1:0] sw;
        logic [OFF_W-1:0]  sh;
        logic [OFF_W-1:0]  off;
        logic [CNT_W-1:0]  n;
    } ctl_t;

    function automatic logic [WORD_BITS-1:0] low_mask(input logic [CNT_W-1:0] n);
        if (n >= CNT_W'(WORD_BITS))
            return '1;
        else
            return (WORD_BITS'(1) << n) - WORD_BITS'(1);
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/brme_store.sv -----
`timescale 1ns / 1ps
`default_nettype none

module brme_store
    import brme_pkg::*;
#(
    parameter int SRC_WORDS = SRC_WORDS_DEF,
    parameter int DST_WORDS = DST_WORDS_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire ctl_t                 ctl,
    input  wire logic [WORD_BITS-1:0] load_data,
    output logic                      busy,
    output logic [WORD_BITS-1:0]      rd_data
);

    localparam int SAW  = (SRC_WORDS > 1) ? $clog2(SRC_WORDS) : 1;
    localparam int DAW  = (DST_WORDS > 1) ? $clog2(DST_WORDS) : 1;
    localparam int MAXW = (SRC_WORDS > DST_WORDS) ? SRC_WORDS : DST_WORDS;
    localparam int CW   = (MAXW > 1) ? $clog2(MAXW) : 1;

    logic [WORD_BITS-1:0] src_mem [SRC_WORDS];
    logic [WORD_BITS-1:0] dst_mem [DST_WORDS];

    logic                 clr_busy_reg;
    logic [CW-1:0]        clr_idx_reg;

    logic [WORD_BITS-1:0] src_lo_reg, src_hi_reg, dst_rd_reg;
    logic                 rd_ok_reg;

    logic                 b_vld_reg;
    logic                 b_fill_reg;
    logic [WIDX_W-1:0]    b_dw_reg;
    logic [OFF_W-1:0]     b_sh_reg;
    logic [OFF_W-1:0]     b_off_reg;
    logic [CNT_W-1:0]     b_n_reg;
    logic                 b_lo_ok_reg;
    logic                 b_hi_ok_reg;

    logic                 src_we, dst_we, src_re, dst_re;
    logic [SAW-1:0]       src_waddr, src_lo_addr, src_hi_addr;
    logic [DAW-1:0]       dst_waddr, dst_raddr;
    logic [WORD_BITS-1:0] src_wdata, dst_wdata;
    logic [WIDX_W:0]      sw_hi;
    logic                 lo_ok, hi_ok;
    logic [WORD_BITS-1:0] lo, hi, gath, lm, val, mask, merged;
    logic [CNT_W-1:0]     sh_inv;

    assign busy = clr_busy_reg;

    // post-reset zero sweep over both stores
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_idx_reg  <= '0;
        end
        else if (clr_busy_reg)
        begin
            if (clr_idx_reg == CW'(MAXW - 1))
                clr_busy_reg <= 1'b0;
            else
                clr_idx_reg <= clr_idx_reg + CW'(1);
        end
    end

    assign sw_hi = {1'b0, ctl.sw} + (WIDX_W+1)'(1);
    assign lo_ok = 32'(ctl.sw) < 32'(SRC_WORDS);
    assign hi_ok = 32'(sw_hi) < 32'(SRC_WORDS);

    always_comb
    begin
        src_we    = 1'b0;
        src_waddr = SAW'(ctl.load_idx);
        src_wdata = load_data;
        if (clr_busy_reg)
        begin
            src_we    = 32'(clr_idx_reg) < 32'(SRC_WORDS);
            src_waddr = SAW'(clr_idx_reg);
            src_wdata = '0;
        end
        else if (ctl.src_load)
        begin
            src_we = 32'(ctl.load_idx) < 32'(SRC_WORDS);
        end
    end

    assign src_re      = ctl.step && !ctl.fill;
    assign src_lo_addr = SAW'(ctl.sw);
    assign src_hi_addr = SAW'(sw_hi);

    assign dst_re    = ctl.dst_read || ctl.step;
    assign dst_raddr = ctl.dst_read ? DAW'(ctl.load_idx) : DAW'(ctl.dw);

    always_ff @(posedge clk)
    begin
        if (src_we)
            src_mem[src_waddr] <= src_wdata;
        if (src_re)
        begin
            src_lo_reg <= src_mem[src_lo_addr];
            src_hi_reg <= src_mem[src_hi_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (dst_we)
            dst_mem[dst_waddr] <= dst_wdata;
        if (dst_re)
            dst_rd_reg <= dst_mem[dst_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_vld_reg <= 1'b0;
            rd_ok_reg <= 1'b0;
        end
        else
        begin
            b_vld_reg <= ctl.step;
            rd_ok_reg <= ctl.dst_read && (32'(ctl.load_idx) < 32'(DST_WORDS));
        end
    end

    always_ff @(posedge clk)
    begin
        b_fill_reg  <= ctl.fill;
        b_dw_reg    <= ctl.dw;
        b_sh_reg    <= ctl.sh;
        b_off_reg   <= ctl.off;
        b_n_reg     <= ctl.n;
        b_lo_ok_reg <= lo_ok;
        b_hi_ok_reg <= hi_ok;
    end

    assign rd_data = rd_ok_reg ? dst_rd_reg : '0;

    // gather source bits from two neighboring words (or ones for a set), merge into the destination word
    assign lo     = b_lo_ok_reg ? src_lo_reg : '0;
    assign hi     = b_hi_ok_reg ? src_hi_reg : '0;
    assign sh_inv = CNT_W'(WORD_BITS) - {1'b0, b_sh_reg};
    assign gath   = (lo >> b_sh_reg) | ((b_sh_reg != '0) ? (hi << sh_inv) : '0);
    assign lm     = low_mask(b_n_reg);
    assign val    = b_fill_reg ? lm : (gath & lm);
    assign mask   = lm << b_off_reg;
    assign merged = (dst_rd_reg & ~mask) | (val << b_off_reg);

    always_comb
    begin
        dst_we    = 1'b0;
        dst_waddr = DAW'(b_dw_reg);
        dst_wdata = merged;
        priority if (clr_busy_reg)
        begin
            dst_we    = 32'(clr_idx_reg) < 32'(DST_WORDS);
            dst_waddr = DAW'(clr_idx_reg);
            dst_wdata = '0;
        end
        else if (ctl.dst_load)
        begin
            dst_we    = 32'(ctl.load_idx) < 32'(DST_WORDS);
            dst_waddr = DAW'(ctl.load_idx);
            dst_wdata = load_data;
        end
        else if (b_vld_reg)
        begin
            dst_we = 1'b1;
        end
        else
        begin
            dst_we = 1'b0;
        end
    end

`ifndef SYNTHESIS
    a_no_op_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        clr_busy_reg |-> !(ctl.src_load || ctl.dst_load || ctl.dst_read || ctl.step))
        else $error("store access during clearing pass");

    a_step_fits_word: assert property (@(posedge clk) disable iff (!rst_n)
        b_vld_reg |-> (b_n_reg != '0 && ({1'b0, b_off_reg} + b_n_reg) <= CNT_W'(WORD_BITS)))
        else $error("step mask exceeds word");

    a_load_not_in_merge: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.dst_load |-> !b_vld_reg)
        else $error("dest load collides with merge write");

    a_steps_distinct_words: assert property (@(posedge clk) disable iff (!rst_n)
        (b_vld_reg && $past(b_vld_reg)) |-> (b_dw_reg == $past(b_dw_reg) + WIDX_W'(1)))
        else $error("back-to-back steps not on consecutive words");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/brme_seq.sv -----
`timescale 1ns / 1ps
`default_nettype none

module brme_seq
    import brme_pkg::*;
#(
    parameter int DST_WORDS = DST_WORDS_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [CMD_W-1:0]     command,
    input  wire logic [IDX_W-1:0]     word_index,
    input  wire logic [WORD_BITS-1:0] word_data,
    input  wire logic [POS_W-1:0]     src_bit_offset,
    input  wire logic [POS_W-1:0]     dst_bit_offset,
    input  wire logic [LEN_W-1:0]     run_length,
    input  wire logic                 busy,
    input  wire logic [WORD_BITS-1:0] rd_data,
    output ctl_t                      ctl,
    output logic [WORD_BITS-1:0]      load_data,
    output logic                      res_vld,
    input  wire logic                 res_rdy,
    output logic [WORD_BITS-1:0]      res_data,
    output logic                      res_err
);

    localparam logic [31:0] DST_BITS = 32'(DST_WORDS * WORD_BITS);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_READ,
        S_RUN,
        S_FIN
    } state_t;

    state_t               state_reg;
    cmd_t                 cmd_reg;
    logic [IDX_W-1:0]     idx_reg;
    logic [WORD_BITS-1:0] data_reg;
    logic [POS_W-1:0]     soff_reg, doff_reg;
    logic [LEN_W-1:0]     len_reg, done_reg;
    logic [WORD_BITS-1:0] res_data_reg;
    logic                 res_err_reg;

    logic [LEN_W-1:0]     pos, spos, rem, done_next;
    logic [CNT_W-1:0]     room, n;
    logic [LEN_W:0]       end_pos;
    logic                 over, last;

    assign pos       = LEN_W'(doff_reg) + done_reg;
    assign spos      = LEN_W'(soff_reg) + done_reg;
    assign rem       = len_reg - done_reg;
    assign room      = CNT_W'(WORD_BITS) - {1'b0, pos[OFF_W-1:0]};
    assign n         = (rem < LEN_W'(room)) ? rem[CNT_W-1:0] : room;
    assign done_next = done_reg + LEN_W'(n);
    assign last      = done_next >= len_reg;
    assign end_pos   = (LEN_W+1)'(doff_reg) + (LEN_W+1)'(len_reg);
    assign over      = 32'(end_pos) > DST_BITS;

    assign in_ready  = (state_reg == S_IDLE) && !busy;
    assign load_data = data_reg;
    assign res_vld   = (state_reg == S_FIN);
    assign res_data  = res_data_reg;
    assign res_err   = res_err_reg;

    always_comb
    begin
        ctl          = '0;
        ctl.src_load = (state_reg == S_EXEC) && (cmd_reg == CMD_LOAD_SRC);
        ctl.dst_load = (state_reg == S_EXEC) && (cmd_reg == CMD_LOAD_DST);
        ctl.dst_read = (state_reg == S_EXEC) && (cmd_reg == CMD_READ_DST);
        ctl.load_idx = idx_reg;
        ctl.step     = (state_reg == S_RUN);
        ctl.fill     = (cmd_reg == CMD_SET);
        ctl.dw       = pos[LEN_W-1:OFF_W];
        ctl.sw       = spos[LEN_W-1:OFF_W];
        ctl.sh       = spos[OFF_W-1:0];
        ctl.off      = pos[OFF_W-1:0];
        ctl.n        = n;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            cmd_reg      <= CMD_LOAD_SRC;
            idx_reg      <= '0;
            data_reg     <= '0;
            soff_reg     <= '0;
            doff_reg     <= '0;
            len_reg      <= '0;
            done_reg     <= '0;
            res_data_reg <= '0;
            res_err_reg  <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid && in_ready)
                    begin
                        cmd_reg   <= cmd_t'(command);
                        idx_reg   <= word_index;
                        data_reg  <= word_data;
                        soff_reg  <= src_bit_offset;
                        doff_reg  <= dst_bit_offset;
                        len_reg   <= run_length;
                        done_reg  <= '0;
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC:
                begin
                    res_data_reg <= '0;
                    res_err_reg  <= 1'b0;
                    unique case (cmd_reg)
                        CMD_READ_DST:
                            state_reg <= S_READ;
                        CMD_MOVE, CMD_SET:
                        begin
                            if (over)
                            begin
                                res_err_reg <= 1'b1;
                                state_reg   <= S_FIN;
                            end
                            else if (len_reg == '0)
                                state_reg <= S_FIN;
                            else
                                state_reg <= S_RUN;
                        end
                        default:
                            state_reg <= S_FIN;
                    endcase
                end
                S_READ:
                begin
                    res_data_reg <= rd_data;
                    state_reg    <= S_FIN;
                end
                S_RUN:
                begin
                    done_reg <= done_next;
                    if (last)
                        state_reg <= S_FIN;
                end
                S_FIN:
                begin
                    if (res_rdy)
                        state_reg <= S_IDLE;
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/bit_run_move_engine_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Accept to result valid: loads, refused or empty runs and unused commands pass EXEC and FIN;
// a destination read adds READ; a run adds one RUN step per destination word it touches (W <= 16).
// A new command is taken only after the last result has gone to the output register; run steps are
// limited by the single read-modify-write port of the destination store (reads overlap the previous write).
// Reset: control clears at once; then a zero sweep runs over both stores, with in_ready low
// until it finishes.

module bit_run_move_engine_unit
    import brme_pkg::*;
#(
    parameter int SRC_WORDS = SRC_WORDS_DEF,
    parameter int DST_WORDS = DST_WORDS_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [CMD_W-1:0]     command,
    input  wire logic [IDX_W-1:0]     word_index,
    input  wire logic [WORD_BITS-1:0] word_data,
    input  wire logic [POS_W-1:0]     src_bit_offset,
    input  wire logic [POS_W-1:0]     dst_bit_offset,
    input  wire logic [LEN_W-1:0]     run_length,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [WORD_BITS-1:0]      read_data,
    output logic                      range_error
);

    ctl_t                 ctl;
    logic [WORD_BITS-1:0] load_data, rd_data, res_data;
    logic                 busy, res_vld, res_rdy, res_err;

    logic                 out_valid_reg;
    logic [WORD_BITS-1:0] read_data_reg;
    logic                 range_error_reg;

    brme_seq #(
        .DST_WORDS (DST_WORDS)
    ) u_seq (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .command        (command),
        .word_index     (word_index),
        .word_data      (word_data),
        .src_bit_offset (src_bit_offset),
        .dst_bit_offset (dst_bit_offset),
        .run_length     (run_length),
        .busy           (busy),
        .rd_data        (rd_data),
        .ctl            (ctl),
        .load_data      (load_data),
        .res_vld        (res_vld),
        .res_rdy        (res_rdy),
        .res_data       (res_data),
        .res_err        (res_err)
    );

    brme_store #(
        .SRC_WORDS (SRC_WORDS),
        .DST_WORDS (DST_WORDS)
    ) u_store (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .load_data (load_data),
        .busy      (busy),
        .rd_data   (rd_data)
    );

    assign res_rdy = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg   <= 1'b0;
            read_data_reg   <= '0;
            range_error_reg <= 1'b0;
        end
        else if (res_vld && res_rdy)
        begin
            out_valid_reg   <= 1'b1;
            read_data_reg   <= res_data;
            range_error_reg <= res_err;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid   = out_valid_reg;
    assign read_data   = read_data_reg;
    assign range_error = range_error_reg;

endmodule

`default_nettype wire

// ----- sim/tb_bit_run_move_engine_unit.sv -----
`timescale 1ns / 1ps

module tb_bit_run_move_engine_unit;
    import brme_pkg::*;

    localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd5;
    localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;
    localparam int STORE_BITS = DST_WORDS_DEF * WORD_BITS;
    localparam int STALL_LIMIT = 4000;
    localparam int HOLD_CYCLES = 300;
    localparam int RANDOM_WORDS = 1100;
    localparam int CALM_WORDS = 100;

    typedef struct {
        logic [WORD_BITS-1:0] data;
        logic                 refused;
    } reply_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    logic [CMD_W-1:0]     command;
    logic [IDX_W-1:0]     word_index;
    logic [WORD_BITS-1:0] word_data;
    logic [POS_W-1:0]     src_bit_offset;
    logic [POS_W-1:0]     dst_bit_offset;
    logic [LEN_W-1:0]     run_length;
    logic                 out_valid;
    logic                 out_ready;
    logic [WORD_BITS-1:0] read_data;
    logic                 range_error;

    logic [WORD_BITS-1:0] src_shadow [SRC_WORDS_DEF];
    logic [WORD_BITS-1:0] dst_shadow [DST_WORDS_DEF];
    reply_t               replies_due [$];

    bit calm = 1'b0;
    bit sender_gaps = 1'b1;
    int hold_request = 0;
    int hold_len;
    int fail_count = 0;
    int stall_cycles = 0;
    int words_sent = 0;
    int replies_seen = 0;
    int moves_done = 0;
    int sets_done = 0;
    int runs_refused = 0;
    int reads_done = 0;

    bit_run_move_engine_unit uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .command        (command),
        .word_index     (word_index),
        .word_data      (word_data),
        .src_bit_offset (src_bit_offset),
        .dst_bit_offset (dst_bit_offset),
        .run_length     (run_length),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .read_data      (read_data),
        .range_error    (range_error)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic logic [WORD_BITS-1:0] ones_below(input int n);
        if (n >= WORD_BITS)
            return '1;
        return (64'd1 << n) - 64'd1;
    endfunction

    function automatic logic [WORD_BITS-1:0] src_at(input int w);
        return (w < SRC_WORDS_DEF) ? src_shadow[w] : '0;
    endfunction

    function automatic logic [WORD_BITS-1:0] gather_bits(input int pos, input int n);
        int                   w;
        int                   sh;
        logic [WORD_BITS-1:0] v;
        w = pos / WORD_BITS;
        sh = pos % WORD_BITS;
        v = src_at(w) >> sh;
        if (sh != 0)
            v = v | (src_at(w + 1) << (WORD_BITS - sh));
        return v & ones_below(n);
    endfunction

    // true when the run would pass the store end; else applies it to dst_shadow
    function automatic logic apply_run(input logic fill, input int soff, input int doff,
                                       input int len);
        int                   done;
        int                   pos;
        int                   w;
        int                   off;
        int                   n;
        logic [WORD_BITS-1:0] mask;
        if (doff + len > STORE_BITS)
            return 1'b1;
        done = 0;
        while (done < len)
        begin
            pos = doff + done;
            w = pos / WORD_BITS;
            off = pos % WORD_BITS;
            n = WORD_BITS - off;
            if (n > len - done)
                n = len - done;
            mask = ones_below(n) << off;
            if (w < DST_WORDS_DEF)
            begin
                if (fill)
                    dst_shadow[w] = dst_shadow[w] | mask;
                else
                    dst_shadow[w] = (dst_shadow[w] & ~mask) |
                                    (gather_bits(soff + done, n) << off);
            end
            done += n;
        end
        return 1'b0;
    endfunction

    function automatic reply_t step_shadow(input logic [CMD_W-1:0] cmd,
                                           input logic [IDX_W-1:0] idx,
                                           input logic [WORD_BITS-1:0] data,
                                           input int soff, input int doff, input int len);
        reply_t r;
        r.data = '0;
        r.refused = 1'b0;
        case (cmd)
            CMD_LOAD_SRC: if (idx < SRC_WORDS_DEF) src_shadow[idx] = data;
            CMD_LOAD_DST: if (idx < DST_WORDS_DEF) dst_shadow[idx] = data;
            CMD_READ_DST:
            begin
                reads_done++;
                if (idx < DST_WORDS_DEF)
                    r.data = dst_shadow[idx];
            end
            CMD_MOVE:
            begin
                moves_done++;
                r.refused = apply_run(1'b0, soff, doff, len);
            end
            CMD_SET:
            begin
                sets_done++;
                r.refused = apply_run(1'b1, 0, doff, len);
            end
            default: ;
        endcase
        if (r.refused)
            runs_refused++;
        return r;
    endfunction

    task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [IDX_W-1:0] idx,
                             input logic [WORD_BITS-1:0] data, input int soff,
                             input int doff, input int len);
        int gap;
        if (sender_gaps && !calm && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 5);
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        command        <= cmd;
        word_index     <= idx;
        word_data      <= data;
        src_bit_offset <= POS_W'(soff);
        dst_bit_offset <= POS_W'(doff);
        run_length     <= LEN_W'(len);
        in_valid       <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        replies_due.push_back(step_shadow(cmd, idx, data, soff, doff, len));
        words_sent++;
        @(negedge clk);
    endtask

    function automatic logic [WORD_BITS-1:0] rand_data();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic int rand_pos();
        case ($urandom_range(0, 4))
            0: return $urandom_range(0, 3);
            1: return $urandom_range(1020, 1023);
            default: return $urandom_range(0, 1023);
        endcase
    endfunction

    function automatic int rand_len(input int doff);
        int room;
        room = STORE_BITS - doff;
        case ($urandom_range(0, 9))
            0: return $urandom_range(0, 1024);
            1: return room;
            2: return 0;
            3, 4, 5, 6: return $urandom_range(0, (room < 130) ? room : 130);
            default: return $urandom_range(0, room);
        endcase
    endfunction

    task automatic send_random_word();
        int                   pick;
        int                   doff;
        logic [CMD_W-1:0]     cmd;
        pick = $urandom_range(0, 99);
        if (pick < 20)
            cmd = CMD_LOAD_SRC;
        else if (pick < 35)
            cmd = CMD_LOAD_DST;
        else if (pick < 60)
            cmd = CMD_READ_DST;
        else if (pick < 82)
            cmd = CMD_MOVE;
        else if (pick < 94)
            cmd = CMD_SET;
        else
            cmd = CMD_W'(CMD_SPARE_LO + $urandom_range(0, CMD_SPARE_HI - CMD_SPARE_LO));
        doff = rand_pos();
        send_word(cmd, IDX_W'($urandom_range(0, 15)), rand_data(), rand_pos(), doff,
                  rand_len(doff));
    endtask

    task automatic test_word_access();
        send_word(CMD_LOAD_SRC, 4'd0,  '1, 0, 0, 0);
        send_word(CMD_LOAD_SRC, 4'd15, 64'h8000_0000_0000_0001, 1023, 1023, 1024);
        send_word(CMD_LOAD_SRC, 4'd7,  64'h0123_4567_89AB_CDEF, 0, 0, 0);
        send_word(CMD_LOAD_DST, 4'd15, '1, 0, 0, 0);
        send_word(CMD_LOAD_DST, 4'd3,  64'hDEAD_BEEF_0BAD_F00D, 0, 0, 0);
        send_word(CMD_READ_DST, 4'd15, '0, 0, 0, 0);
        send_word(CMD_READ_DST, 4'd3,  '1, 1023, 1023, 1024);
        send_word(CMD_READ_DST, 4'd0,  '0, 0, 0, 0);
    endtask

    task automatic test_runs();
        send_word(CMD_MOVE, 4'd0, '0, 0, 0, 64);          // aligned word
        send_word(CMD_MOVE, 4'd0, '0, 5, 70, 100);        // unaligned both sides
        send_word(CMD_MOVE, 4'd0, '0, 1000, 128, 50);     // source tail reads as zero
        send_word(CMD_MOVE, 4'd0, '0, 1023, 300, 1);
        send_word(CMD_MOVE, 4'd0, '0, 3, 0, 1024);        // whole store
        send_word(CMD_MOVE, 4'd0, '0, 0, 1000, 100);      // overrun
        send_word(CMD_MOVE, 4'd0, '0, 0, 1023, 2);        // overrun by one
        send_word(CMD_MOVE, 4'd0, '0, 960, 1023, 1);
        send_word(CMD_MOVE, 4'd0, '0, 0, 1023, 0);        // empty
        send_word(CMD_SET,  4'd0, '0, 0, 33, 200);
        send_word(CMD_SET,  4'd0, '0, 0, 960, 64);
        send_word(CMD_SET,  4'd0, '0, 0, 100, 0);
        send_word(CMD_SET,  4'd0, '0, 0, 1, 1024);        // overrun
        send_word(CMD_SPARE_LO, 4'd5, '1, 1023, 1023, 1024);
        send_word(CMD_SPARE_HI, 4'd9, '1, 0, 0, 0);
        for (int i = 0; i < 16; i += 5)
            send_word(CMD_READ_DST, IDX_W'(i), '0, 0, 0, 0);
    endtask

    task automatic test_backpressure();
        sender_gaps = 1'b0;
        hold_request = HOLD_CYCLES;
        repeat (40) send_random_word();
        sender_gaps = 1'b1;
    endtask

    task automatic test_random_mix();
        repeat (RANDOM_WORDS) send_random_word();
    endtask

    task automatic test_steady_stream();
        calm = 1'b1;
        repeat (CALM_WORDS) send_random_word();
    endtask

    initial
    begin
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        command        = '0;
        word_index     = '0;
        word_data      = '0;
        src_bit_offset = '0;
        dst_bit_offset = '0;
        run_length     = '0;
        for (int i = 0; i < SRC_WORDS_DEF; i++)
            src_shadow[i] = '0;
        for (int i = 0; i < DST_WORDS_DEF; i++)
            dst_shadow[i] = '0;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_word_access();
        test_runs();
        test_backpressure();
        test_random_mix();
        test_steady_stream();
        in_valid <= 1'b0;
        while (replies_due.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        $display("sent %0d words, checked %0d results", words_sent, replies_seen);
        $display("runs: %0d moves, %0d sets, %0d refused; %0d reads",
                 moves_done, sets_done, runs_refused, reads_done);
        if (fail_count == 0)
            $display("tb_bit_run_move_engine_unit: PASS");
        else
            $display("tb_bit_run_move_engine_unit: FAIL");
        $finish;
    end

    // receiver: random back-pressure bursts plus one long hold on request
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request != 0)
            begin
                hold_len = hold_request;
                hold_request = 0;
                out_ready <= 1'b0;
                repeat (hold_len - 1) @(negedge clk);
            end
            else if (!calm && $urandom_range(0, 5) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(0, 4)) @(negedge clk);
            end
            else
                out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        reply_t want;
        if (rst_n && out_valid && out_ready)
        begin
            replies_seen++;
            if (replies_due.size() == 0)
            begin
                $error("unexpected result: read_data %h range_error %b", read_data,
                       range_error);
                fail_count++;
            end
            else
            begin
                want = replies_due.pop_front();
                if (read_data !== want.data)
                begin
                    $error("read_data: expected %h, got %h", want.data, read_data);
                    fail_count++;
                end
                if (range_error !== want.refused)
                begin
                    $error("range_error: expected %b, got %b", want.refused, range_error);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("timeout: %0d results still expected", replies_due.size());
            $display("tb_bit_run_move_engine_unit: FAIL");
            $finish;
        end
    end

endmodule
